@@ src/srtf_scheduler_top_macros.svh @@
// Assertion macros used by the scheduler controller.
`ifndef SRTF_SCHEDULER_TOP_MACROS_SVH
`define SRTF_SCHEDULER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRTF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SRTF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/srtf_pkg.sv @@
package srtf_pkg;

  // Table size and derived widths.
  localparam int MAX_JOBS     = 16;
  localparam int SLOT_W       = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CNT_W        = $clog2(MAX_JOBS + 1);
  localparam int DATA_W       = 16;
  localparam int TIME_W       = 24;
  localparam int SLOT_FIELD_W = 4;
  localparam int SLOT_EXT_W   = (SLOT_W > SLOT_FIELD_W) ? SLOT_W : SLOT_FIELD_W;

  localparam logic [TIME_W-1:0] CLOCK_MAX = '1;

  // Opcodes of an input beat.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef struct packed {
    logic              opcode;
    logic [DATA_W-1:0] arrival;
    logic [DATA_W-1:0] burst;
  } in_t;

  typedef struct packed {
    logic [TIME_W-1:0]       tick_time;
    logic [SLOT_FIELD_W-1:0] chosen_slot;
    logic                    is_idle;
    logic                    is_switch;
    logic                    job_done;
    logic [TIME_W-1:0]       finish_time;
    logic [TIME_W-1:0]       turnaround;
    logic [TIME_W-1:0]       wait_span;
    logic                    all_finished;
  } out_t;

  // Job table write and read port.
  typedef struct packed {
    logic              wr_all;
    logic              wr_rem;
    slot_t             waddr;
    logic [DATA_W-1:0] arrival;
    logic [DATA_W-1:0] burst;
    logic [DATA_W-1:0] rem;
    slot_t             raddr;
  } tbl_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] arrival;
    logic [DATA_W-1:0] burst;
    logic [DATA_W-1:0] rem;
  } tbl_rd_t;

  // Low bits of a slot number as carried in the result.
  function automatic logic [SLOT_FIELD_W-1:0] slot_field(input slot_t slot);
    logic [SLOT_EXT_W-1:0] ext;
    ext = SLOT_EXT_W'(slot);
    return ext[SLOT_FIELD_W-1:0];
  endfunction

endpackage

@@ src/srtf_scheduler_top.sv @@
// Load beats produce no result; the next beat is taken at once.
// A tick beat scans the loaded jobs with one comparator at one entry per cycle, then
// fetches, updates and reports; the next beat is taken once the report step hands
// its result to the output register.
// A result held in the output register stalls the next tick in its report step.
// Synchronous active-low reset empties the table and clears clock, counts and last choice.
module srtf_scheduler_top
  import srtf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  in_t  in_data,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  tbl_req_t tbl_req;
  tbl_rd_t  tbl_rd;
  logic     res_ready;
  logic     res_valid;
  out_t     res_data;
  logic     out_valid_r, out_valid_nxt;
  out_t     out_data_r;

  srtf_job_table u_table (
    .clk (clk),
    .req (tbl_req),
    .rd  (tbl_rd)
  );

  srtf_sched_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .tbl_req   (tbl_req),
    .tbl_rd    (tbl_rd),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  // Output register: refilled when empty or when its beat is taken.
  assign res_ready     = !out_valid_r || !out_stall;
  assign out_valid_nxt = res_valid || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ src/srtf_job_table.sv @@
module srtf_job_table
  import srtf_pkg::*;
(
  input  logic     clk,
  input  tbl_req_t req,
  output tbl_rd_t  rd
);

  logic [DATA_W-1:0] arrival_mem [MAX_JOBS];
  logic [DATA_W-1:0] burst_mem   [MAX_JOBS];
  logic [DATA_W-1:0] rem_mem     [MAX_JOBS];

  // A load writes the whole entry; a tick rewrites only the remaining time.
  always_ff @(posedge clk) begin
    if (req.wr_all) begin
      arrival_mem[req.waddr] <= req.arrival;
      burst_mem[req.waddr]   <= req.burst;
    end
    if (req.wr_all || req.wr_rem) begin
      rem_mem[req.waddr] <= req.rem;
    end
  end

  // Single registered read port.
  always_ff @(posedge clk) begin
    rd.arrival <= arrival_mem[req.raddr];
    rd.burst   <= burst_mem[req.raddr];
    rd.rem     <= rem_mem[req.raddr];
  end

endmodule

@@ src/srtf_sched_ctrl.sv @@
module srtf_sched_ctrl
  import srtf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  in_t      in_data,
  output logic     in_stall,
  output tbl_req_t tbl_req,
  input  tbl_rd_t  tbl_rd,
  input  logic     res_ready,
  output logic     res_valid,
  output out_t     res_data
);

  `include "srtf_scheduler_top_macros.svh"

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_FETCH, S_UPDATE, S_REPORT} state_t;
  typedef enum logic [1:0] {CH_NONE, CH_IDLE, CH_SLOT} choice_t;

  state_t            state_r, state_nxt;
  cnt_t              loaded_r, loaded_nxt;
  cnt_t              finished_r, finished_nxt;
  logic [TIME_W-1:0] clock_r, clock_nxt;
  choice_t           last_kind_r, last_kind_nxt;
  slot_t             last_slot_r, last_slot_nxt;
  cnt_t              idx_r, idx_nxt;
  logic              pv_r, pv_nxt;
  logic              found_r, found_nxt;

  slot_t             pidx_r;
  slot_t             best_r;
  logic [DATA_W-1:0] best_rem_r;
  logic [DATA_W-1:0] best_arr_r;
  logic [TIME_W-1:0] start_r;
  logic [TIME_W-1:0] fin_r;
  logic [TIME_W-1:0] tat_r;
  logic [DATA_W-1:0] burst_r;
  logic              done_r;
  logic              switch_r;
  logic              allfin_r;

  logic              accept;
  logic              issuing;
  logic              eligible;
  logic              better;
  logic              take;
  logic [TIME_W-1:0] clock_inc;
  logic [TIME_W-1:0] tat_calc;
  logic [TIME_W-1:0] wait_calc;
  logic [DATA_W-1:0] rem_dec;
  logic              is_switch_calc;

  assign accept  = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign issuing = (idx_r < loaded_r);

  // Shared compare unit: one table entry per cycle against the best so far.
  assign eligible = (TIME_W'(tbl_rd.arrival) <= clock_r) && (tbl_rd.rem != '0);
  assign better   = !found_r || (tbl_rd.rem < best_rem_r) ||
                    ((tbl_rd.rem == best_rem_r) && (tbl_rd.arrival < best_arr_r));
  assign take     = (state_r == S_SCAN) && pv_r && eligible && better;

  // Update arithmetic for the chosen job.
  assign clock_inc = (clock_r == CLOCK_MAX) ? clock_r : clock_r + TIME_W'(1);
  assign rem_dec   = best_rem_r - DATA_W'(1);
  assign tat_calc  = clock_inc - TIME_W'(tbl_rd.arrival);
  assign wait_calc = (tat_r >= TIME_W'(burst_r)) ? tat_r - TIME_W'(burst_r) : '0;

  always_comb begin
    if (found_r) begin
      is_switch_calc = !((last_kind_r == CH_SLOT) && (last_slot_r == best_r));
    end else begin
      is_switch_calc = (last_kind_r != CH_IDLE);
    end
  end

  // Table port: loads write at accept, scan and fetch read, update writes back.
  always_comb begin
    tbl_req         = '0;
    tbl_req.arrival = in_data.arrival;
    tbl_req.burst   = in_data.burst;
    tbl_req.rem     = in_data.burst;
    tbl_req.waddr   = loaded_r[SLOT_W-1:0];
    tbl_req.raddr   = (state_r == S_SCAN) ? idx_r[SLOT_W-1:0] : best_r;
    if (accept && (in_data.opcode == OP_LOAD) && (loaded_r < CNT_W'(MAX_JOBS)) &&
        (in_data.burst != '0)) begin
      tbl_req.wr_all = 1'b1;
    end
    if ((state_r == S_UPDATE) && found_r) begin
      tbl_req.wr_rem = 1'b1;
      tbl_req.waddr  = best_r;
      tbl_req.rem    = rem_dec;
    end
  end

  // Sequencer next state.
  always_comb begin
    state_nxt     = state_r;
    loaded_nxt    = loaded_r;
    finished_nxt  = finished_r;
    clock_nxt     = clock_r;
    last_kind_nxt = last_kind_r;
    last_slot_nxt = last_slot_r;
    idx_nxt       = idx_r;
    pv_nxt        = 1'b0;
    found_nxt     = found_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_data.opcode == OP_TICK) begin
            state_nxt = S_SCAN;
            idx_nxt   = '0;
            found_nxt = 1'b0;
          end else if (tbl_req.wr_all) begin
            loaded_nxt = loaded_r + CNT_W'(1);
          end
        end
      end
      S_SCAN: begin
        if (take) begin
          found_nxt = 1'b1;
        end
        if (issuing) begin
          idx_nxt = idx_r + CNT_W'(1);
          pv_nxt  = 1'b1;
        end else begin
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        clock_nxt = clock_inc;
        if (found_r) begin
          last_kind_nxt = CH_SLOT;
          last_slot_nxt = best_r;
          if (best_rem_r == DATA_W'(1)) begin
            finished_nxt = finished_r + CNT_W'(1);
          end
        end else begin
          last_kind_nxt = CH_IDLE;
        end
        state_nxt = S_REPORT;
      end
      S_REPORT: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      loaded_r    <= '0;
      finished_r  <= '0;
      clock_r     <= '0;
      last_kind_r <= CH_NONE;
      last_slot_r <= '0;
      idx_r       <= '0;
      pv_r        <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      loaded_r    <= loaded_nxt;
      finished_r  <= finished_nxt;
      clock_r     <= clock_nxt;
      last_kind_r <= last_kind_nxt;
      last_slot_r <= last_slot_nxt;
      idx_r       <= idx_nxt;
      pv_r        <= pv_nxt;
      found_r     <= found_nxt;
    end
  end

  // Datapath registers: best candidate and the figures of the tick.
  always_ff @(posedge clk) begin
    pidx_r <= idx_r[SLOT_W-1:0];
    if (take) begin
      best_r     <= pidx_r;
      best_rem_r <= tbl_rd.rem;
      best_arr_r <= tbl_rd.arrival;
    end
    if (state_r == S_UPDATE) begin
      start_r  <= clock_r;
      fin_r    <= clock_inc;
      tat_r    <= tat_calc;
      burst_r  <= tbl_rd.burst;
      done_r   <= found_r && (best_rem_r == DATA_W'(1));
      switch_r <= is_switch_calc;
      allfin_r <= (finished_nxt == loaded_r);
    end
  end

  // Result beat.
  assign res_valid = (state_r == S_REPORT) && res_ready;

  always_comb begin
    res_data              = '0;
    res_data.tick_time    = start_r;
    res_data.chosen_slot  = found_r ? slot_field(best_r) : '0;
    res_data.is_idle      = !found_r;
    res_data.is_switch    = switch_r;
    res_data.job_done     = done_r;
    res_data.all_finished = allfin_r;
    if (done_r) begin
      res_data.finish_time = fin_r;
      res_data.turnaround  = tat_r;
      res_data.wait_span   = wait_calc;
    end
  end

  `SRTF_ASSERT_NOW(a_finished_le_loaded, 1'b1, finished_r <= loaded_r,
    "finished count exceeds loaded count")
  `SRTF_ASSERT_NEXT(a_update_to_report, state_r == S_UPDATE, state_r == S_REPORT,
    "update step not followed by report")
  `SRTF_ASSERT_NOW(a_best_in_range, (state_r == S_UPDATE) && found_r,
    CNT_W'(best_r) < loaded_r, "chosen slot beyond loaded jobs")
  `SRTF_ASSERT_NEXT(a_clock_moves_once, state_r != S_UPDATE, $stable(clock_r),
    "clock changed outside the update step")

endmodule
